/* rtl/ghr_pkg.sv */
// Shared types, constants and the arctangent table for goal_heading_and_reach.
// Used by every module in rtl/; depends on nothing else.
package ghr_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SQRT_STEPS        = 32;
    localparam int XY_W              = 36;
    localparam int Z_W               = 35;
    localparam int CFG_IDX_W         = 3;

    localparam logic signed [Z_W-1:0] PI_Q30   = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] HEAD_MAX = 35'sd25736;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_00   = 3'd0,
        REG_ROT_01   = 3'd1,
        REG_ROT_02   = 3'd2,
        REG_ROT_20   = 3'd3,
        REG_ROT_21   = 3'd4,
        REG_ROT_22   = 3'd5,
        REG_REACH    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        distance;
        logic signed [15:0] heading_angle;
        logic               reached;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } t_rot;

    // Data handed from cell to cell: square root remainder and root, and the
    // CORDIC vector with its angle accumulator.
    typedef struct packed {
        logic [63:0]           rem;
        logic [63:0]           root;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                  zero;
    } t_cell_data;

    // atan(2^-i) in Q2.30, truncated.
    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 35'sd843314856;
            1:  v = 35'sd497837829;
            2:  v = 35'sd263043836;
            3:  v = 35'sd133525158;
            4:  v = 35'sd67021686;
            5:  v = 35'sd33543515;
            6:  v = 35'sd16775850;
            7:  v = 35'sd8388437;
            8:  v = 35'sd4194282;
            9:  v = 35'sd2097149;
            10: v = 35'sd1048575;
            11: v = 35'sd524287;
            12: v = 35'sd262143;
            13: v = 35'sd131071;
            14: v = 35'sd65535;
            15: v = 35'sd32767;
            16: v = 35'sd16383;
            17: v = 35'sd8191;
            18: v = 35'sd4095;
            19: v = 35'sd2047;
            20: v = 35'sd1023;
            21: v = 35'sd511;
            22: v = 35'sd255;
            23: v = 35'sd127;
            24: v = 35'sd63;
            25: v = 35'sd31;
            26: v = 35'sd15;
            27: v = 35'sd7;
            28: v = 35'sd3;
            29: v = 35'sd1;
            default: v = 35'sd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/ghr_front.sv */
// Front end: difference, frame rotation, squares and CORDIC setup, five stages.
// Depends on ghr_pkg.
module ghr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ghr_pkg::t_in_item    i_data,
    input  ghr_pkg::t_rot        i_rot,
    output logic                 o_valid,
    output ghr_pkg::t_cell_data  o_data
);

    localparam logic signed [49:0] SUM_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SUM_MIN = -50'sd2147483648;
    localparam logic signed [32:0] DIF_MAX = 33'sd2147483647;
    localparam logic signed [32:0] DIF_MIN = -33'sd2147483648;

    logic r_v0, r_v1, r_v2, r_v3, r_v4;

    logic signed [31:0] r_dx, r_dy, r_dz;
    logic signed [47:0] r_p00, r_p01, r_p02, r_p20, r_p21, r_p22;
    logic signed [31:0] r_a, r_c;
    logic [63:0]        r_a2, r_c2;
    logic signed [ghr_pkg::XY_W-1:0] r_x3, r_y3;
    logic signed [ghr_pkg::Z_W-1:0]  r_z3;
    logic               r_zero3;
    ghr_pkg::t_cell_data r_out;

    function automatic logic signed [31:0] sat_dif(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > DIF_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < DIF_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Round half up from Q18.30 to Q16.16 and saturate.
    function automatic logic signed [31:0] round_row(input logic signed [47:0] p0,
                                                     input logic signed [47:0] p1,
                                                     input logic signed [47:0] p2);
        logic signed [49:0] s;
        logic signed [49:0] sh;
        logic signed [31:0] r;
        s  = 50'(p0) + 50'(p1) + 50'(p2) + 50'sd8192;
        sh = s >>> 14;
        if (sh > SUM_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (sh < SUM_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = sh[31:0];
        end
        return r;
    endfunction

    logic signed [32:0] n_dx, n_dy, n_dz;
    logic signed [ghr_pkg::XY_W-1:0] n_ax, n_cy;
    logic signed [63:0] n_a2, n_c2;

    assign n_dx = 33'(i_data.goal_x) - 33'(i_data.pos_x);
    assign n_dy = 33'(i_data.goal_y) - 33'(i_data.pos_y);
    assign n_dz = 33'(i_data.goal_z) - 33'(i_data.pos_z);
    assign n_ax = ghr_pkg::XY_W'(r_a);
    assign n_cy = -(ghr_pkg::XY_W'(r_c));
    assign n_a2 = r_a * r_a;
    assign n_c2 = r_c * r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= sat_dif(n_dx);
            r_dy  <= sat_dif(n_dy);
            r_dz  <= sat_dif(n_dz);

            r_p00 <= i_rot.r00 * r_dx;
            r_p01 <= i_rot.r01 * r_dy;
            r_p02 <= i_rot.r02 * r_dz;
            r_p20 <= i_rot.r20 * r_dx;
            r_p21 <= i_rot.r21 * r_dy;
            r_p22 <= i_rot.r22 * r_dz;

            r_a   <= round_row(r_p00, r_p01, r_p02);
            r_c   <= round_row(r_p20, r_p21, r_p22);

            r_a2  <= $unsigned(n_a2);
            r_c2  <= $unsigned(n_c2);
            r_zero3 <= (r_a == 32'sd0) && (r_c == 32'sd0);
            // Left half plane: negate the vector and start from +pi or -pi.
            if (r_a < 32'sd0) begin
                r_x3 <= -n_ax;
                r_y3 <= -n_cy;
                r_z3 <= (n_cy > 0) ? ghr_pkg::PI_Q30 : -ghr_pkg::PI_Q30;
            end else begin
                r_x3 <= n_ax;
                r_y3 <= n_cy;
                r_z3 <= '0;
            end

            r_out.rem  <= r_a2 + r_c2;
            r_out.root <= '0;
            r_out.x    <= r_x3;
            r_out.y    <= r_y3;
            r_out.z    <= r_z3;
            r_out.zero <= r_zero3;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_out;

endmodule

/* rtl/ghr_cell.sv */
// One cell of the chain: one square root step and, in the first cells, one
// CORDIC vectoring step. Depends on ghr_pkg.
module ghr_cell #(
    parameter int IDX           = 0,
    parameter int CORDIC_STAGES = ghr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ghr_pkg::t_cell_data  i_data,
    output logic                 o_valid,
    output ghr_pkg::t_cell_data  o_data
);

    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * IDX);
    localparam logic signed [ghr_pkg::Z_W-1:0] ATAN = ghr_pkg::atan_q30(IDX);
    localparam bit ROT_ON = (IDX < CORDIC_STAGES);

    logic                r_valid;
    ghr_pkg::t_cell_data r_data;
    ghr_pkg::t_cell_data n_data;

    logic [63:0] trial;
    logic signed [ghr_pkg::XY_W-1:0] xs, ys;

    assign trial = i_data.root + SQ_BIT;
    assign xs    = i_data.x >>> IDX;
    assign ys    = i_data.y >>> IDX;

    always_comb begin
        n_data = i_data;
        if (i_data.rem >= trial) begin
            n_data.rem  = i_data.rem - trial;
            n_data.root = (i_data.root >> 1) + SQ_BIT;
        end else begin
            n_data.root = i_data.root >> 1;
        end
        if (ROT_ON) begin
            if (i_data.y > 0) begin
                n_data.x = i_data.x + ys;
                n_data.y = i_data.y - xs;
                n_data.z = i_data.z + ATAN;
            end else begin
                n_data.x = i_data.x - ys;
                n_data.y = i_data.y + xs;
                n_data.z = i_data.z - ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/ghr_out_skid.sv */
// Two-entry output buffer that decouples the chain from the receiver.
// Depends on ghr_pkg.
module ghr_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ghr_pkg::t_out_item  i_data,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output ghr_pkg::t_out_item  o_data
);

    logic [1:0]         r_cnt;
    ghr_pkg::t_out_item r_q0, r_q1;
    logic               pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    // A push is allowed when an entry is free or one leaves in the same cycle.
    assign o_space = (r_cnt != 2'd2) || i_ready;
    assign o_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({i_push, pop})
                2'b10: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd0) begin
                        r_q0 <= i_data;
                    end else begin
                        r_q1 <= i_data;
                    end
                end
                2'b01: begin
                    r_cnt <= r_cnt - 2'd1;
                    r_q0  <= r_q1;
                end
                2'b11: begin
                    if (r_cnt == 2'd1) begin
                        r_q0 <= i_data;
                    end else begin
                        r_q0 <= r_q1;
                        r_q1 <= i_data;
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

endmodule

/* rtl/goal_heading_and_reach.sv */
// Top level of goal_heading_and_reach: configuration registers, front end,
// cell chain and output buffer. Depends on ghr_pkg, ghr_front, ghr_cell, ghr_out_skid.
//
// Usage:
//   Input requests (goal and current position, signed Q16.16) arrive on the
//   i_in_valid / o_in_ready channel; each gives exactly one result request
//   (distance, heading, reached) on o_out_valid / i_out_ready, in order.
//   Configuration writes (matrix rows 0 and 2, reach radius) come on the
//   i_cfg_valid / o_cfg_ready channel, which is always ready; write them only
//   while no request is in flight. An index beyond the list is ignored.
//   A request passes five front stages (difference, products, row sums, squares,
//   sum of squares), a chain of 32 cells that each retire one bit of the square
//   root and, in the first CORDIC_STAGES cells, one CORDIC step, then the
//   output buffer.
//   Throughput: one request per cycle while the output buffer has space.
//   When the receiver stalls, the two-entry output buffer fills and then the
//   whole pipeline holds, dropping o_in_ready; nothing is lost.
//   Reset clears all valid bits and loads the identity matrix and a radius
//   of 0.25.
module goal_heading_and_reach #(
    parameter int CORDIC_STAGES = ghr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ghr_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ghr_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ghr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    ghr_pkg::t_rot r_rot;
    logic [31:0]   r_radius;

    logic en;
    logic skid_space;

    logic                w_valid [0:ghr_pkg::SQRT_STEPS];
    ghr_pkg::t_cell_data w_data  [0:ghr_pkg::SQRT_STEPS];

    ghr_pkg::t_cell_data last;
    ghr_pkg::t_out_item  result;
    logic signed [ghr_pkg::Z_W-1:0] z_round;
    logic signed [ghr_pkg::Z_W-1:0] z_clamp;

    assign o_cfg_ready = 1'b1;
    assign en          = skid_space;
    assign o_in_ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.r00 <= 16'sd16384;
            r_rot.r01 <= 16'sd0;
            r_rot.r02 <= 16'sd0;
            r_rot.r20 <= 16'sd0;
            r_rot.r21 <= 16'sd0;
            r_rot.r22 <= 16'sd16384;
            r_radius  <= 32'd16384;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ghr_pkg::REG_ROT_00: r_rot.r00 <= i_cfg_data[15:0];
                ghr_pkg::REG_ROT_01: r_rot.r01 <= i_cfg_data[15:0];
                ghr_pkg::REG_ROT_02: r_rot.r02 <= i_cfg_data[15:0];
                ghr_pkg::REG_ROT_20: r_rot.r20 <= i_cfg_data[15:0];
                ghr_pkg::REG_ROT_21: r_rot.r21 <= i_cfg_data[15:0];
                ghr_pkg::REG_ROT_22: r_rot.r22 <= i_cfg_data[15:0];
                ghr_pkg::REG_REACH:  r_radius  <= i_cfg_data;
                default: begin
                    r_radius <= r_radius;
                end
            endcase
        end
    end

    ghr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_rot   (r_rot),
        .o_valid (w_valid[0]),
        .o_data  (w_data[0])
    );

    for (genvar g = 0; g < ghr_pkg::SQRT_STEPS; g++) begin : g_cell
        ghr_cell #(
            .IDX           (g),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // Round the Q2.30 angle to Q3.13 and clamp to +-pi.
    assign last    = w_data[ghr_pkg::SQRT_STEPS];
    assign z_round = (last.z + 35'sd65536) >>> 17;

    always_comb begin
        if (z_round > ghr_pkg::HEAD_MAX) begin
            z_clamp = ghr_pkg::HEAD_MAX;
        end else if (z_round < -ghr_pkg::HEAD_MAX) begin
            z_clamp = -ghr_pkg::HEAD_MAX;
        end else begin
            z_clamp = z_round;
        end
        result.distance      = last.root[31:0];
        result.heading_angle = last.zero ? 16'sd0 : z_clamp[15:0];
        result.reached       = (r_radius > last.root[31:0]);
    end

    ghr_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && w_valid[ghr_pkg::SQRT_STEPS]),
        .i_data  (result),
        .o_space (skid_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

/* sim/goal_heading_and_reach_test.sv */
// Self-checking testbench for goal_heading_and_reach: random and directed goal/position
// requests against a behavioral predictor, under several matrix and radius settings.
// Depends on ghr_pkg and the goal_heading_and_reach RTL.
`timescale 1ns / 1ps

module goal_heading_and_reach_test;

    localparam int     CORDIC_STEPS = 16;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = 60;
    localparam longint PI_Q30_L     = 64'sd3373259426;
    localparam longint HEADING_MAX  = 64'sd25736;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
    localparam logic [ghr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    ghr_pkg::t_in_item  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ghr_pkg::t_out_item out_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ghr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data = '0;

    // Shadow copy of the block's configuration.
    ghr_pkg::t_rot mirror_rot;
    logic [31:0]   mirror_radius;

    ghr_pkg::t_in_item  pending_items[$];
    ghr_pkg::t_out_item expected_results[$];
    int        idle_pct = 35;
    int        mismatch_count = 0;
    int        cycle_count = 0;

    longint arctan_q30 [16] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767
    };

    goal_heading_and_reach #(
        .CORDIC_STAGES(CORDIC_STEPS)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [31:0] sat_word(longint v);
        if (v > longint'(WORD_MAX)) return WORD_MAX;
        if (v < longint'(WORD_MIN)) return WORD_MIN;
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] rotate_row(logic signed [15:0] m0,
                                                      logic signed [15:0] m1,
                                                      logic signed [15:0] m2,
                                                      logic signed [31:0] d0,
                                                      logic signed [31:0] d1,
                                                      logic signed [31:0] d2);
        longint acc;
        acc = longint'(m0) * longint'(d0) + longint'(m1) * longint'(d1)
            + longint'(m2) * longint'(d2);
        return sat_word((acc + 64'sd8192) >>> 14);
    endfunction

    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = v;
        root  = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[31:0];
    endfunction

    // Vectoring CORDIC on (vx, vy); the angle is kept in Q2.30 until the end.
    function automatic logic signed [15:0] cordic_heading(longint vx, longint vy);
        longint px;
        longint py;
        longint ang;
        longint sx;
        longint sy;
        px  = vx;
        py  = vy;
        ang = 0;
        if (px == 0 && py == 0) return '0;
        // Fold the left half plane over and start from plus or minus pi.
        if (px < 0) begin
            ang = (py > 0) ? PI_Q30_L : -PI_Q30_L;
            px  = -px;
            py  = -py;
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            sx = px >>> k;
            sy = py >>> k;
            if (py > 0) begin
                px  = px + sy;
                py  = py - sx;
                ang = ang + arctan_q30[k];
            end else begin
                px  = px - sy;
                py  = py + sx;
                ang = ang - arctan_q30[k];
            end
        end
        ang = (ang + 64'sd65536) >>> 17;
        if (ang > HEADING_MAX) ang = HEADING_MAX;
        if (ang < -HEADING_MAX) ang = -HEADING_MAX;
        return 16'(ang);
    endfunction

    function automatic ghr_pkg::t_out_item compute_heading_reach(ghr_pkg::t_in_item it);
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [31:0] ra;
        logic signed [31:0] rc;
        logic [63:0]        sq;
        ghr_pkg::t_out_item res;
        dx = sat_word(longint'(it.goal_x) - longint'(it.pos_x));
        dy = sat_word(longint'(it.goal_y) - longint'(it.pos_y));
        dz = sat_word(longint'(it.goal_z) - longint'(it.pos_z));
        ra = rotate_row(mirror_rot.r00, mirror_rot.r01, mirror_rot.r02, dx, dy, dz);
        rc = rotate_row(mirror_rot.r20, mirror_rot.r21, mirror_rot.r22, dx, dy, dz);
        sq = 64'(longint'(ra) * longint'(ra)) + 64'(longint'(rc) * longint'(rc));
        res.distance      = floor_sqrt(sq);
        res.heading_angle = cordic_heading(longint'(ra), -longint'(rc));
        res.reached       = mirror_radius > res.distance;
        return res;
    endfunction

    function automatic void apply_reg(logic [ghr_pkg::CFG_IDX_W-1:0] idx,
                                      logic [31:0] value);
        case (idx)
            ghr_pkg::REG_ROT_00: mirror_rot.r00 = value[15:0];
            ghr_pkg::REG_ROT_01: mirror_rot.r01 = value[15:0];
            ghr_pkg::REG_ROT_02: mirror_rot.r02 = value[15:0];
            ghr_pkg::REG_ROT_20: mirror_rot.r20 = value[15:0];
            ghr_pkg::REG_ROT_21: mirror_rot.r21 = value[15:0];
            ghr_pkg::REG_ROT_22: mirror_rot.r22 = value[15:0];
            ghr_pkg::REG_REACH:  mirror_radius  = value;
            default: ;
        endcase
    endfunction

    function automatic logic signed [31:0] near_offset();
        logic [31:0] raw;
        int          mag;
        mag = $urandom_range(0, 26);
        raw = $urandom & ((32'd1 << mag) - 32'd1);
        return ($urandom_range(0, 1) != 0) ? -$signed(raw) : $signed(raw);
    endfunction

    function automatic logic signed [31:0] corner_value();
        case ($urandom_range(0, 5))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return 32'sd0;
            3: return 32'sd1;
            4: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly positions close to the goal, so that reached and small headings occur.
    function automatic ghr_pkg::t_in_item random_item();
        ghr_pkg::t_in_item it;
        int       style;
        style = $urandom_range(0, 9);
        it.goal_x = $urandom;
        it.goal_y = $urandom;
        it.goal_z = $urandom;
        it.pos_x  = $urandom;
        it.pos_y  = $urandom;
        it.pos_z  = $urandom;
        if (style < 6) begin
            it.pos_x = it.goal_x - near_offset();
            it.pos_y = it.goal_y - near_offset();
            it.pos_z = it.goal_z - near_offset();
        end else if (style < 8) begin
            it.goal_x = corner_value();
            it.goal_y = corner_value();
            it.goal_z = corner_value();
            it.pos_x  = corner_value();
            it.pos_y  = corner_value();
            it.pos_z  = corner_value();
        end
        return it;
    endfunction

    task automatic push_item(logic signed [31:0] gx, logic signed [31:0] gy,
                             logic signed [31:0] gz, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] pz);
        ghr_pkg::t_in_item it;
        it.goal_x = gx;
        it.goal_y = gy;
        it.goal_z = gz;
        it.pos_x  = px;
        it.pos_y  = py;
        it.pos_z  = pz;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) pending_items.push_back(random_item());
        wait_drained();
    endtask

    // Called at a rising edge; returns at the edge where the request was taken.
    task automatic write_reg(logic [ghr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, value);
    endtask

    // The upper halves of the matrix writes carry junk that the block must drop.
    task automatic load_registers(logic [15:0] r00, logic [15:0] r01, logic [15:0] r02,
                                  logic [15:0] r20, logic [15:0] r21, logic [15:0] r22,
                                  logic [31:0] radius);
        @(posedge clk);
        write_reg(ghr_pkg::REG_ROT_00, {16'($urandom), r00});
        write_reg(ghr_pkg::REG_ROT_01, {16'($urandom), r01});
        write_reg(ghr_pkg::REG_ROT_02, {16'($urandom), r02});
        write_reg(ghr_pkg::REG_ROT_20, {16'($urandom), r20});
        write_reg(ghr_pkg::REG_ROT_21, {16'($urandom), r21});
        write_reg(ghr_pkg::REG_ROT_22, {16'($urandom), r22});
        write_reg(ghr_pkg::REG_REACH, radius);
        write_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_extremes();
        push_item(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN);
        push_item(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
        push_item(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        push_item(ONE_Q16, -ONE_Q16, 32'sd1, 0, 0, 0);
        push_item(0, 0, 0, 0, 0, 0);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(compute_heading_reach(in_data));
            end
            if (!in_valid || in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        ghr_pkg::t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: got %h", $time, out_data);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.distance !== want.distance) begin
                        $display("%0t: distance mismatch: expected %0d, actual %0d",
                                 $time, want.distance, out_data.distance);
                        mismatch_count++;
                    end
                    if (out_data.heading_angle !== want.heading_angle) begin
                        $display("%0t: heading mismatch: expected %0d, actual %0d",
                                 $time, want.heading_angle, out_data.heading_angle);
                        mismatch_count++;
                    end
                    if (out_data.reached !== want.reached) begin
                        $display("%0t: reached mismatch: expected %0b, actual %0b",
                                 $time, want.reached, out_data.reached);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= $urandom_range(0, 99) >= idle_pct;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        mirror_rot    = '{r00: 16'sd16384, r01: '0, r02: '0, r20: '0, r21: '0,
                          r22: 16'sd16384};
        mirror_radius = 32'd16384;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: identity matrix, so a follows x and c follows z.
        push_item(0, 0, 0, 0, 0, 0);
        push_item(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX);
        push_item(-ONE_Q16, 0, 0, 0, 0, 0);
        push_item(-ONE_Q16, 0, ONE_Q16, 0, 0, 0);
        push_item(-ONE_Q16, 0, -ONE_Q16, 0, 0, 0);
        push_item(ONE_Q16, 0, 0, 0, 0, 0);
        push_item(0, 0, ONE_Q16, 0, 0, 0);
        push_item(0, 0, -ONE_Q16, 0, 0, 0);
        push_item(WORD_MAX, 0, 0, WORD_MIN, 0, 0);
        push_item(WORD_MIN, 0, 0, WORD_MAX, 0, 0);
        push_item(WORD_MAX, 0, WORD_MAX, WORD_MIN, 0, WORD_MIN);
        push_item(WORD_MIN, 0, WORD_MIN, WORD_MAX, 0, WORD_MAX);
        push_item(0, WORD_MAX, 0, 0, WORD_MIN, 0);
        push_item(32'sd16383, 0, 0, 0, 0, 0);
        push_item(32'sd16384, 0, 0, 0, 0, 0);
        push_item(-32'sd1, 0, 0, 0, 0, 0);
        push_item(32'sd1, 0, 0, 0, 0, 0);
        push_item(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        push_item(WORD_MAX, WORD_MAX, WORD_MAX, 0, 0, 0);
        push_item(0, 0, 0, WORD_MIN, WORD_MIN, WORD_MIN);
        wait_drained();
        run_random(200);

        load_registers(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                       32'hFFFF_FFFF);
        push_extremes();
        run_random(180);

        // No idling on either side for this whole setting.
        load_registers(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                       32'h0000_0000);
        idle_pct = 0;
        push_extremes();
        run_random(180);
        idle_pct = 35;

        for (int phase = 0; phase < 6; phase++) begin
            load_registers(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom),
                           ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1 << 22)
                                                       : $urandom);
            run_random(200);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
